/* hdl/rrip_adaptive_insertion_replacer_core_macros.svh */
// Assertion macros for the RRIP replacement engine.
// Included by the core; assertions vanish when SYNTHESIS is defined.
`ifndef RRIP_ADAPTIVE_INSERTION_REPLACER_CORE_MACROS_SVH
`define RRIP_ADAPTIVE_INSERTION_REPLACER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RRIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrip core check failed");
// Next-cycle implication, checked outside reset.
`define RRIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrip core check failed");
`else
`define RRIP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RRIP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rrip_pkg.sv */
// Shared constants and types for the RRIP replacement engine.
// No dependencies; used by rrip_adaptive_insertion_replacer_core.
package rrip_pkg;

    // Field widths of the channels
    localparam int SET_IDX_W  = 11;
    localparam int WAY_IDX_W  = 4;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 20;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    // Width of count * 100 and pct * count products
    localparam int PROD_W     = CNT_W + PCT_W;

    // Default geometry
    localparam int DEF_NUM_SETS   = 2048;
    localparam int DEF_NUM_WAYS   = 16;
    localparam int DEF_REREF_BITS = 3;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Insertion modes
    localparam mode_t MODE_MRU    = 2'd0;
    localparam mode_t MODE_BYPASS = 2'd1;
    localparam mode_t MODE_SRRIP  = 2'd2;

    // Operations
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Register indexes
    localparam cfg_idx_t CFG_EPOCH_LEN  = 2'd0;
    localparam cfg_idx_t CFG_THRASH_PCT = 2'd1;
    localparam cfg_idx_t CFG_HIT_PCT    = 2'd2;

    // Register reset values
    localparam logic [CNT_W-1:0] DEF_EPOCH_LEN  = 20'd500000;
    localparam logic [PCT_W-1:0] DEF_THRASH_PCT = 7'd60;
    localparam logic [PCT_W-1:0] DEF_HIT_PCT    = 7'd50;

    // Percent scale of the epoch tests
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

endpackage

/* hdl/rrip_adaptive_insertion_replacer_core.sv */
// RRIP replacement engine with per-epoch adaptive insertion (MRU, bypass, SRRIP).
// Depends on rrip_pkg and rrip_adaptive_insertion_replacer_core_macros.svh.
// Result word: loaded from ST_EXEC, or from ST_EPOCH when an update ends an epoch.
// No new request is taken until the current one's row write-back (and epoch close) is done;
// a result word still held by the receiver stalls the write-back.
// Reset: a clearing pass writes every set row (NUM_SETS rows, 2048 by default),
// with s_ready low; configuration writes are taken throughout.
`include "rrip_adaptive_insertion_replacer_core_macros.svh"

module rrip_adaptive_insertion_replacer_core #(
    parameter int NUM_SETS   = rrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS   = rrip_pkg::DEF_NUM_WAYS,
    parameter int REREF_BITS = rrip_pkg::DEF_REREF_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [rrip_pkg::SET_IDX_W-1:0]    s_set_index,
    input  logic [rrip_pkg::WAY_IDX_W-1:0]    s_way_index,
    input  logic                              s_was_hit,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rrip_pkg::WAY_IDX_W-1:0]    m_victim_way,
    output logic [rrip_pkg::MODE_W-1:0]       m_insert_mode,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrip_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_AW   = $clog2(NUM_WAYS);
    localparam int NLEV     = 2 ** REREF_BITS;
    localparam bit SET_POW2 = (NUM_SETS > 1) && ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam bit WAY_POW2 = (NUM_WAYS & (NUM_WAYS - 1)) == 0;

    localparam logic [REREF_BITS-1:0] RMAX      = '1;
    localparam logic [REREF_BITS-1:0] RINS_LONG = RMAX - REREF_BITS'(1);
    localparam logic [SET_AW-1:0]     SET_LAST  = SET_AW'(NUM_SETS - 1);

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_EPOCH = 2'd3;

    typedef logic [NUM_WAYS-1:0][REREF_BITS-1:0] rrow_t;
    typedef logic [NUM_WAYS-1:0]                 mrow_t;

    // Reduce a set index modulo NUM_SETS by conditional subtraction
    function automatic logic [SET_AW-1:0] set_mod(input logic [rrip_pkg::SET_IDX_W-1:0] x);
        logic [31:0] r;
        r = 32'(x);
        if (!SET_POW2) begin
            for (int k = rrip_pkg::SET_IDX_W - 1; k >= 0; k--) begin
                if (r >= (32'(NUM_SETS) << k)) begin
                    r = r - (32'(NUM_SETS) << k);
                end
            end
        end
        return r[SET_AW-1:0];
    endfunction

    // Reduce a way index modulo NUM_WAYS
    function automatic logic [WAY_AW-1:0] way_mod(input logic [rrip_pkg::WAY_IDX_W-1:0] x);
        logic [31:0] r;
        r = 32'(x);
        if (!WAY_POW2) begin
            for (int k = rrip_pkg::WAY_IDX_W - 1; k >= 0; k--) begin
                if (r >= (32'(NUM_WAYS) << k)) begin
                    r = r - (32'(NUM_WAYS) << k);
                end
            end
        end
        return r[WAY_AW-1:0];
    endfunction

    // Set memories
    rrow_t reref_mem [NUM_SETS];
    mrow_t mark_mem  [NUM_SETS];

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [SET_AW-1:0] clr_cnt_reg;
    logic              m_valid_reg, m_valid_next;

    // Captured request word and row read data
    logic                   op_reg;
    logic [SET_AW-1:0]      set_reg;
    logic [WAY_AW-1:0]      way_reg;
    logic                   hit_reg;
    rrow_t                  rrow_rd_reg;
    mrow_t                  mrow_rd_reg;

    // Result word
    logic [WAY_AW-1:0]      victim_out_reg;
    rrip_pkg::mode_t        mode_out_reg;

    // Adaptation state and registers
    rrip_pkg::mode_t              mode_reg;
    logic [rrip_pkg::CNT_W-1:0]   event_cnt_reg, hit_cnt_reg, miss_cnt_reg, thrash_cnt_reg;
    logic [rrip_pkg::CNT_W-1:0]   epoch_len_reg;
    logic [rrip_pkg::PCT_W-1:0]   thrash_pct_reg, hit_pct_reg;

    // Datapath signals
    logic                         accept, out_free, out_load, cnt_upd, cnt_clr;
    logic                         mem_we;
    logic [SET_AW-1:0]            mem_waddr;
    rrow_t                        rrow_wr, rrow_aged, rrow_upd;
    mrow_t                        mrow_wr, mrow_upd;
    logic [NLEV-1:0]              level_seen;
    logic [REREF_BITS-1:0]        top_lvl, ins_val;
    logic [NUM_WAYS-1:0]          at_top, low_top;
    logic [WAY_AW-1:0]            victim_way;
    logic [WAY_AW-1:0]            victim_out_next;
    rrip_pkg::mode_t              mode_out_next, mode_pick;
    logic                         thrash_now, epoch_end;
    logic [rrip_pkg::CNT_W-1:0]   event_inc;
    logic [rrip_pkg::PROD_W-1:0]  thr, thr_lim, hr, hr_lim;
    logic [WAY_AW+rrip_pkg::WAY_IDX_W-1:0] victim_ext;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Read the set row at accept; write back in ST_EXEC at the earliest,
    // so consecutive words on the same set never overlap in the memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            reref_mem[mem_waddr] <= rrow_wr;
            mark_mem[mem_waddr]  <= mrow_wr;
        end
        if (accept) begin
            rrow_rd_reg <= reref_mem[set_mod(s_set_index)];
            mrow_rd_reg <= mark_mem[set_mod(s_set_index)];
        end
    end

    // Capture the request word
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_operation;
            set_reg <= set_mod(s_set_index);
            way_reg <= way_mod(s_way_index);
            hit_reg <= s_was_hit;
        end
    end

    // Age the set: find the top level, lift all ways by RMAX - top, pick lowest at top
    always_comb begin
        level_seen = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            level_seen[rrow_rd_reg[w]] = 1'b1;
        end
        top_lvl = '0;
        for (int l = 0; l < NLEV; l++) begin
            if (level_seen[l]) begin
                top_lvl = REREF_BITS'(l);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            at_top[w]    = (rrow_rd_reg[w] == top_lvl);
            rrow_aged[w] = rrow_rd_reg[w] + (RMAX - top_lvl);
        end
        low_top    = at_top & (~at_top + NUM_WAYS'(1));
        victim_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (low_top[w]) begin
                victim_way = victim_way | WAY_AW'(w);
            end
        end
    end

    // Apply a hit or a fill to the addressed way
    always_comb begin
        case (mode_reg)
            rrip_pkg::MODE_MRU:    ins_val = '0;
            rrip_pkg::MODE_BYPASS: ins_val = RMAX;
            default:               ins_val = RINS_LONG;
        endcase
        rrow_upd          = rrow_rd_reg;
        mrow_upd          = mrow_rd_reg;
        rrow_upd[way_reg] = hit_reg ? '0 : ins_val;
        mrow_upd[way_reg] = hit_reg;
        thrash_now        = !hit_reg && !mrow_rd_reg[way_reg];
        event_inc         = event_cnt_reg + rrip_pkg::CNT_W'(1);
        epoch_end         = (event_inc >= epoch_len_reg);
    end

    // Choose the next mode from the registered epoch counts
    always_comb begin
        thr     = rrip_pkg::PROD_W'(thrash_cnt_reg) * rrip_pkg::PROD_W'(rrip_pkg::PCT_SCALE);
        thr_lim = rrip_pkg::PROD_W'(thrash_pct_reg) * rrip_pkg::PROD_W'(miss_cnt_reg);
        hr      = rrip_pkg::PROD_W'(hit_cnt_reg) * rrip_pkg::PROD_W'(rrip_pkg::PCT_SCALE);
        hr_lim  = rrip_pkg::PROD_W'(hit_pct_reg) * rrip_pkg::PROD_W'(event_cnt_reg);
        if (thr > thr_lim) begin
            mode_pick = rrip_pkg::MODE_BYPASS;
        end else if (hr > hr_lim) begin
            mode_pick = rrip_pkg::MODE_MRU;
        end else begin
            mode_pick = rrip_pkg::MODE_SRRIP;
        end
    end

    // Sequencer: clear, wait, read-modify-write, optional epoch close
    always_comb begin
        state_next      = state_reg;
        mem_we          = 1'b0;
        mem_waddr       = set_reg;
        rrow_wr         = rrow_aged;
        mrow_wr         = mrow_rd_reg;
        out_load        = 1'b0;
        victim_out_next = '0;
        mode_out_next   = mode_reg;
        cnt_upd         = 1'b0;
        cnt_clr         = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                rrow_wr   = {NUM_WAYS{RMAX}};
                mrow_wr   = '0;
                if (clr_cnt_reg == SET_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    mem_we = 1'b1;
                    if (op_reg == rrip_pkg::OP_UPDATE) begin
                        rrow_wr = rrow_upd;
                        mrow_wr = mrow_upd;
                        cnt_upd = 1'b1;
                        if (epoch_end) begin
                            state_next = ST_EPOCH;
                        end else begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        out_load        = 1'b1;
                        victim_out_next = victim_way;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_EPOCH: begin
                if (out_free) begin
                    cnt_clr       = 1'b1;
                    out_load      = 1'b1;
                    mode_out_next = mode_pick;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Advance sequencer and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_AW'(1);
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            victim_out_reg <= victim_out_next;
            mode_out_reg   <= mode_out_next;
        end
    end

    // Count epoch events; close the epoch with a new mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= rrip_pkg::MODE_SRRIP;
            event_cnt_reg  <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            thrash_cnt_reg <= '0;
        end else if (cnt_clr) begin
            mode_reg       <= mode_pick;
            event_cnt_reg  <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            thrash_cnt_reg <= '0;
        end else if (cnt_upd) begin
            event_cnt_reg <= event_inc;
            if (hit_reg) begin
                hit_cnt_reg <= hit_cnt_reg + rrip_pkg::CNT_W'(1);
            end else begin
                miss_cnt_reg <= miss_cnt_reg + rrip_pkg::CNT_W'(1);
            end
            if (thrash_now) begin
                thrash_cnt_reg <= thrash_cnt_reg + rrip_pkg::CNT_W'(1);
            end
        end
    end

    // Configuration registers; writes to unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_len_reg  <= rrip_pkg::DEF_EPOCH_LEN;
            thrash_pct_reg <= rrip_pkg::DEF_THRASH_PCT;
            hit_pct_reg    <= rrip_pkg::DEF_HIT_PCT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rrip_pkg::CFG_EPOCH_LEN:  epoch_len_reg  <= cfg_data[rrip_pkg::CNT_W-1:0];
                rrip_pkg::CFG_THRASH_PCT: thrash_pct_reg <= cfg_data[rrip_pkg::PCT_W-1:0];
                rrip_pkg::CFG_HIT_PCT:    hit_pct_reg    <= cfg_data[rrip_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Drive the result ports; the victim way keeps its low four bits
    assign victim_ext    = {{rrip_pkg::WAY_IDX_W{1'b0}}, victim_out_reg};
    assign m_valid       = m_valid_reg;
    assign m_victim_way  = victim_ext[rrip_pkg::WAY_IDX_W-1:0];
    assign m_insert_mode = mode_out_reg;

    // Checks
    `RRIP_ASSERT_IMPL(a_no_rw_overlap, aclk, aresetn, accept, !mem_we)
    `RRIP_ASSERT_IMPL(a_cnt_sum, aclk, aresetn, 1'b1, rrip_pkg::CNT_W'(hit_cnt_reg + miss_cnt_reg) == event_cnt_reg)
    `RRIP_ASSERT_IMPL(a_thrash_le_miss, aclk, aresetn, 1'b1, thrash_cnt_reg <= miss_cnt_reg)
    `RRIP_ASSERT_NEXT(a_exec_done, aclk, aresetn, state_reg == ST_EXEC && out_free, m_valid_reg || state_reg == ST_EPOCH)

endmodule
